// ===== rtl/core/lgp_pkg.sv =====
package lgp_pkg;

  localparam int COORD_W = 8;
  localparam int LOD_W   = 2;
  localparam int SIDE_W  = 9;
  localparam int IDX_W   = 17;
  // step = 1 << lod, lod < 2**LOD_W
  localparam int STEP_W  = 1 << LOD_W;
  localparam int CNT_W   = STEP_W - 1;
  localparam int LAST_W  = SIDE_W + 2;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(17);

  // One triangle shape per code; the loop codes walk the edge with the accumulator
  typedef enum logic [3:0] {
    OP_N0,     // plain cell, first triangle
    OP_N1,     // plain cell, second triangle
    OP_CA,     // fan, left side triangle
    OP_CB,     // fan, right side triangle
    OP_RA,     // fan, bottom side triangle
    OP_RB,     // fan, top side triangle
    OP_LEFT,   // fan, left edge walk
    OP_RIGHT,  // fan, right edge walk
    OP_TOP,    // fan, top edge walk
    OP_BOT     // fan, bottom edge walk
  } op_t;

  typedef struct packed {
    logic load;   // take the input item
    logic mul;    // row offset and side products
    logic prep;   // cell base indices and fan center
    logic emit;   // write one triangle to the output register
    op_t  op;
    logic last;   // final triangle of the cell
  } dp_cmd_t;

  typedef struct packed {
    logic             border;
    logic             col_first;
    logic             col_last;
    logic             row_first;
    logic             row_last;
    logic [CNT_W-1:0] step_m1;
    logic             out_free;
  } dp_sts_t;

endpackage

// ===== rtl/core/lgp_if.sv =====
interface lgp_in_if;
  logic                        valid;
  logic                        ready;
  logic [lgp_pkg::COORD_W-1:0] cell_col;
  logic [lgp_pkg::COORD_W-1:0] cell_row;
  logic [lgp_pkg::LOD_W-1:0]   detail_level;

  modport source(output valid, output cell_col, output cell_row, output detail_level,
                 input ready);
  modport sink(input valid, input cell_col, input cell_row, input detail_level,
               output ready);
endinterface

interface lgp_out_if;
  logic                      valid;
  logic                      ready;
  logic [lgp_pkg::IDX_W-1:0] vertex_a;
  logic [lgp_pkg::IDX_W-1:0] vertex_b;
  logic [lgp_pkg::IDX_W-1:0] vertex_c;
  logic                      final_triangle;

  modport source(output valid, output vertex_a, output vertex_b, output vertex_c,
                 output final_triangle, input ready);
  modport sink(input valid, input vertex_a, input vertex_b, input vertex_c,
               input final_triangle, output ready);
endinterface

// ===== rtl/core/lgp_datapath.sv =====
module lgp_datapath #(
  parameter int LOD_LEVELS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lgp_pkg::SIDE_W-1:0]   cfg_data,
  input  logic [lgp_pkg::COORD_W-1:0]  in_col,
  input  logic [lgp_pkg::COORD_W-1:0]  in_row,
  input  logic [lgp_pkg::LOD_W-1:0]    in_lod,
  input  lgp_pkg::dp_cmd_t             cmd,
  output lgp_pkg::dp_sts_t             sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lgp_pkg::IDX_W-1:0]    out_a,
  output logic [lgp_pkg::IDX_W-1:0]    out_b,
  output logic [lgp_pkg::IDX_W-1:0]    out_c,
  output logic                         out_last
);
  import lgp_pkg::*;

  localparam logic [LOD_W-1:0] LOD_MAX = LOD_W'(LOD_LEVELS - 1);

  logic [SIDE_W-1:0]  side_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic [LOD_W-1:0]   lod_r;
  logic [IDX_W-1:0]   off_r, ss_r, hh_r, sps_r;
  logic [IDX_W-1:0]   xo_r, xss_r, mid_r, acc_r;
  logic               col_first_r, col_last_r, row_first_r, row_last_r, border_r;
  logic               out_valid_r, out_last_r;
  logic [IDX_W-1:0]   out_a_r, out_b_r, out_c_r;

  logic [STEP_W-1:0]        step, half;
  logic [IDX_W-1:0]         step_x, side_x, hs;
  logic signed [LAST_W-1:0] lastv;
  logic [IDX_W-1:0]         va, vb, vc, acc_nxt, xo_n;
  logic                     out_free;

  assign step   = STEP_W'(1) << lod_r;
  assign half   = step >> 1;
  assign step_x = IDX_W'(step);
  assign side_x = IDX_W'(side_r);
  assign hs     = (lod_r == '0) ? '0 : (side_x << (lod_r - LOD_W'(1)));
  // last column/row index of a full cell; negative never matches
  assign lastv  = $signed(LAST_W'(side_r)) - $signed(LAST_W'(1)) - $signed(LAST_W'(step));
  assign xo_n   = IDX_W'(col_r) + off_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    va      = mid_r;
    vb      = '0;
    vc      = '0;
    acc_nxt = acc_r;
    unique case (cmd.op)
      OP_N0: begin
        va = xo_r;          vb = xo_r + step_x;   vc = xss_r;
      end
      OP_N1: begin
        va = xo_r + step_x; vb = xss_r + step_x;  vc = xss_r;
      end
      OP_CA: begin
        vb = xss_r;          vc = xo_r;           acc_nxt = xo_r;
      end
      OP_CB: begin
        vb = xo_r + step_x;  vc = xss_r + step_x; acc_nxt = xo_r;
      end
      OP_RA: begin
        vb = xss_r + step_x; vc = xss_r;          acc_nxt = xo_r;
      end
      OP_RB: begin
        vb = xo_r;           vc = xo_r + step_x;  acc_nxt = xss_r;
      end
      OP_LEFT: begin
        vb = acc_r + side_x; vc = acc_r;          acc_nxt = acc_r + side_x;
      end
      OP_RIGHT: begin
        vb = acc_r + step_x; vc = acc_r + sps_r;  acc_nxt = acc_r + side_x;
      end
      OP_TOP: begin
        vb = acc_r;          vc = acc_r + IDX_W'(1); acc_nxt = acc_r + IDX_W'(1);
      end
      OP_BOT: begin
        vb = acc_r + IDX_W'(1); vc = acc_r;       acc_nxt = acc_r + IDX_W'(1);
      end
      default: begin
        vb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= SIDE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        side_r <= cfg_data;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= in_col;
      row_r <= in_row;
      lod_r <= (in_lod > LOD_MAX) ? LOD_MAX : in_lod;
    end
    if (cmd.mul) begin
      off_r       <= IDX_W'(row_r) * side_x;
      ss_r        <= side_x << lod_r;
      hh_r        <= IDX_W'(half) + hs;
      sps_r       <= side_x + step_x;
      col_first_r <= (col_r == '0);
      row_first_r <= (row_r == '0);
      col_last_r  <= (lastv == $signed(LAST_W'(col_r)));
      row_last_r  <= (lastv == $signed(LAST_W'(row_r)));
      border_r    <= (lod_r != '0) && ((col_r == '0) || (row_r == '0) ||
                     (lastv == $signed(LAST_W'(col_r))) ||
                     (lastv == $signed(LAST_W'(row_r))));
    end
    if (cmd.prep) begin
      xo_r  <= xo_n;
      xss_r <= xo_n + ss_r;
      mid_r <= xo_n + hh_r;
    end
    if (cmd.emit) begin
      acc_r      <= acc_nxt;
      out_a_r    <= va;
      out_b_r    <= vb;
      out_c_r    <= vc;
      out_last_r <= cmd.last;
    end
  end

  assign sts.border    = border_r;
  assign sts.col_first = col_first_r;
  assign sts.col_last  = col_last_r;
  assign sts.row_first = row_first_r;
  assign sts.row_last  = row_last_r;
  assign sts.step_m1   = CNT_W'(step - STEP_W'(1));
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_a     = out_a_r;
  assign out_b     = out_b_r;
  assign out_c     = out_c_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/core/lgp_ctrl.sv =====
module lgp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lgp_pkg::dp_sts_t sts,
  output lgp_pkg::dp_cmd_t cmd
);
  import lgp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_N0,
    ST_N1,
    ST_COL_HEAD,
    ST_COL_LOOP,
    ST_COL_TAIL,
    ST_ROW_HEAD,
    ST_ROW_LOOP,
    ST_ROW_TAIL
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_end;

  assign cnt_end  = (cnt_r == sts.step_m1);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '{load: 1'b0, mul: 1'b0, prep: 1'b0, emit: 1'b0, op: OP_N0, last: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.border ? ST_COL_HEAD : ST_N0;
      end
      ST_N0: begin
        cmd.emit = sts.out_free;
        cmd.op   = OP_N0;
        if (sts.out_free) state_nxt = ST_N1;
      end
      ST_N1: begin
        cmd.emit = sts.out_free;
        cmd.op   = OP_N1;
        cmd.last = 1'b1;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_COL_HEAD: begin
        cmd.emit = sts.out_free;
        cmd.op   = sts.col_first ? OP_CB : OP_CA;
        cnt_nxt  = '0;
        if (sts.out_free) begin
          state_nxt = (sts.col_first || sts.col_last) ? ST_COL_LOOP : ST_COL_TAIL;
        end
      end
      ST_COL_LOOP: begin
        cmd.emit = sts.out_free;
        cmd.op   = sts.col_first ? OP_LEFT : OP_RIGHT;
        if (sts.out_free) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_end) state_nxt = ST_ROW_HEAD;
        end
      end
      ST_COL_TAIL: begin
        cmd.emit = sts.out_free;
        cmd.op   = OP_CB;
        if (sts.out_free) state_nxt = ST_ROW_HEAD;
      end
      ST_ROW_HEAD: begin
        cmd.emit = sts.out_free;
        cmd.op   = sts.row_first ? OP_RA : OP_RB;
        cnt_nxt  = '0;
        if (sts.out_free) begin
          state_nxt = (sts.row_first || sts.row_last) ? ST_ROW_LOOP : ST_ROW_TAIL;
        end
      end
      ST_ROW_LOOP: begin
        cmd.emit = sts.out_free;
        cmd.op   = sts.row_first ? OP_TOP : OP_BOT;
        cmd.last = cnt_end;
        if (sts.out_free) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_end) state_nxt = ST_IDLE;
        end
      end
      ST_ROW_TAIL: begin
        cmd.emit = sts.out_free;
        cmd.op   = OP_RA;
        cmd.last = 1'b1;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/lod_grid_patch_index_generator_top.sv =====
// Terrain patch index generator. Each input item names one grid cell (left column,
// top row, level of detail) of a square patch whose side, in vertices, sits in the
// cfg register (reset 17). The block answers with the cell's triangles as vertex index
// triples (row * side + column, kept to 17 bits), one triangle per output item, with
// final_triangle set on the last. Interior cells and all level 0 cells give two
// triangles; a border cell at a coarser level gives a fan around its center vertex
// with one triangle per fine segment along the patch edge, so it meets finer
// neighbors without cracks: 3 + step or 2 + 2 * step triangles, step = 2**level.
// Level is limited to LOD_LEVELS - 1. Cells off the grid or off the step alignment
// are not refused; the same formulas apply.
// Timing: one item at a time. The accepting cycle is followed by the setup states
// (row multiply, then base and center sums), then one triangle per cycle while the
// output is taken. The output register lets the last triangle wait while the next
// item is already accepted.
// Write the side register only while the block is idle.
module lod_grid_patch_index_generator_top #(
  parameter int LOD_LEVELS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lgp_pkg::SIDE_W-1:0] cfg_data,
  lgp_in_if.sink                     in_ch,
  lgp_out_if.source                  out_ch
);
  import lgp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing: which triangle comes next and when the output slot is free
  lgp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // index arithmetic, edge walk accumulator and output register
  lgp_datapath #(
    .LOD_LEVELS (LOD_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_col    (in_ch.cell_col),
    .in_row    (in_ch.cell_row),
    .in_lod    (in_ch.detail_level),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_a     (out_ch.vertex_a),
    .out_b     (out_ch.vertex_b),
    .out_c     (out_ch.vertex_c),
    .out_last  (out_ch.final_triangle)
  );

endmodule
